[sv/pled_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and the log table builder of the peak energy level detector
package pled_pkg;

  // field widths
  localparam int unsigned SampleW   = 16;
  localparam int unsigned PeakW     = 15;
  localparam int unsigned PosW      = 10;
  localparam int unsigned EnergyW   = 32;
  localparam int unsigned LenW      = 11;
  localparam int unsigned AmpW      = 8;
  localparam int unsigned VolW      = 12;
  localparam int unsigned StepW     = 16;
  localparam int unsigned LevelW    = 16;
  localparam int unsigned ActW      = 24;
  localparam int unsigned TableW    = 16;

  // mean peak carries 8 fraction bits
  localparam int unsigned FracBits  = 8;
  localparam int unsigned NumW      = EnergyW + LenW + FracBits;
  localparam int unsigned QIdxW     = $clog2(NumW);
  // bits kept after the leading one of the mean peak
  localparam int unsigned FracW     = 32;

  localparam int unsigned LenMax        = 1024;
  localparam int unsigned COUNTER_SCALE = 16;
  localparam int unsigned CntShift      = $clog2(COUNTER_SCALE);
  localparam int unsigned LN2_Q16       = 45426;
  localparam int unsigned Ln2W          = 16;
  localparam int unsigned VOLUME_MAX    = 4095;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SUB_LEN     = 3'd0,
    REG_AMPLIFY     = 3'd1,
    REG_THRESHOLD   = 3'd2,
    REG_RISE_STEP   = 3'd3,
    REG_FALL_STEP   = 3'd4,
    REG_COUNTER_MAX = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last_in_buffer;
  } in_item_t;

  typedef struct packed {
    logic [LevelW-1:0] activity_level;
    logic [VolW-1:0]   volume;
  } out_item_t;

  // closed buffer handed from front to back
  typedef struct packed {
    logic [EnergyW-1:0] energy;
    logic [LenW-1:0]    len;
  } job_t;

  typedef struct packed {
    logic [AmpW-1:0]  amplify;
    logic [VolW-1:0]  threshold;
    logic [StepW-1:0] rise_step;
    logic [StepW-1:0] fall_step;
    logic [StepW-1:0] counter_max;
  } back_cfg_t;

  // log2 of a q30 value in [1,2) as a q16 fraction, by repeated squaring
  function automatic logic [TableW-1:0] log2_frac(input logic [63:0] x0);
    logic [63:0]       x;
    logic [TableW-1:0] r;
    x = x0;
    r = '0;
    for (int k = 0; k < TableW; k++) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        r[TableW-1-k] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

[sv/peak_energy_level_detector.sv]
`timescale 1ns / 1ps
// top level: configuration registers, front end, job queue, back end and result queue
//
//  channel   dir  handshake               beat
//  input     in   push / full             in_item_i  (sample, last_in_buffer)
//  result    out  pop / empty             out_item_o (activity_level, volume)
//  config    in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one sample a cycle is taken while the two-entry job queue has room.
// for each buffer end the back end runs the one-bit-a-cycle mean peak divider over all
// 51 quotient bits, then the table index, table read, two multiplies, volume and counter update.
// reset clears the peak, energy, count and activity state and loads register defaults.
// full rises only when two buffer ends wait for the back end; a stalled pop holds
// results in the two-entry result queue and then holds the back end.
module peak_energy_level_detector
  import pled_pkg::*;
#(
  parameter int unsigned MAX_BUFFER_SAMPLES = 4096,
  parameter int unsigned LOG_TABLE_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  in_item_t            in_item_i,
  input  logic                pop,
  output logic                empty,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned CntW  = $clog2(MAX_BUFFER_SAMPLES + 1);
  localparam int unsigned JobW  = $bits(job_t) + CntW;
  localparam int unsigned ResW  = $bits(out_item_t);

  localparam logic [LenW-1:0]  SubLenReset   = 11'd100;
  localparam logic [AmpW-1:0]  AmplifyReset  = 8'd10;
  localparam logic [VolW-1:0]  ThreshReset   = 12'd40;
  localparam logic [StepW-1:0] RiseReset     = 16'd16;
  localparam logic [StepW-1:0] FallReset     = 16'd1;
  localparam logic [StepW-1:0] CntMaxReset   = 16'd100;

  logic [LenW-1:0] sub_len_q;
  back_cfg_t       cfg_q;

  logic            in_accept;
  logic            job_push, job_full, job_empty, job_pop;
  job_t            job_in, job_out;
  logic [CntW-1:0] job_cnt_in, job_cnt_out;
  logic [JobW-1:0] job_rdata;
  logic            res_push, res_full;
  out_item_t       res_in;
  logic [ResW-1:0] res_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_len_q         <= SubLenReset;
      cfg_q.amplify     <= AmplifyReset;
      cfg_q.threshold   <= ThreshReset;
      cfg_q.rise_step   <= RiseReset;
      cfg_q.fall_step   <= FallReset;
      cfg_q.counter_max <= CntMaxReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SUB_LEN:     sub_len_q         <= cfg_data_i[LenW-1:0];
        REG_AMPLIFY:     cfg_q.amplify     <= cfg_data_i[AmpW-1:0];
        REG_THRESHOLD:   cfg_q.threshold   <= cfg_data_i[VolW-1:0];
        REG_RISE_STEP:   cfg_q.rise_step   <= cfg_data_i[StepW-1:0];
        REG_FALL_STEP:   cfg_q.fall_step   <= cfg_data_i[StepW-1:0];
        REG_COUNTER_MAX: cfg_q.counter_max <= cfg_data_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  assign full      = job_full;
  assign in_accept = push && !full;

  pled_front #(
    .MAX_BUFFER_SAMPLES (MAX_BUFFER_SAMPLES),
    .CNT_W              (CntW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_accept),
    .item_i     (in_item_i),
    .sub_len_i  (sub_len_q),
    .job_push_o (job_push),
    .job_o      (job_in),
    .job_cnt_o  (job_cnt_in)
  );

  pled_fifo #(
    .WIDTH (JobW),
    .DEPTH (2)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (job_push),
    .wdata_i ({job_in, job_cnt_in}),
    .full_o  (job_full),
    .rd_i    (job_pop),
    .rdata_o (job_rdata),
    .empty_o (job_empty)
  );

  assign {job_out, job_cnt_out} = job_rdata;

  pled_back #(
    .CNT_W           (CntW),
    .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_cnt_i   (job_cnt_out),
    .job_pop_o   (job_pop),
    .cfg_i       (cfg_q),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  pled_fifo #(
    .WIDTH (ResW),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .rd_i    (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign out_item_o = out_item_t'(res_rdata);

  // the front relies on full to keep buffer ends from overrunning the job queue
  a_job_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !job_full)
    else $error("buffer end pushed into a full job queue");

  a_full_from_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(job_push))
    else $error("full rose without a buffer end");

  a_result_from_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty) |-> $past(res_push))
    else $error("result appeared without a back end beat");

endmodule

[sv/pled_fifo.sv]
`timescale 1ns / 1ps
// small first-word-fall-through register queue
module pled_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

[sv/pled_front.sv]
`timescale 1ns / 1ps
// per-sample peak hold, run energy and buffer count; hands closed buffers to the back end
module pled_front
  import pled_pkg::*;
#(
  parameter int unsigned MAX_BUFFER_SAMPLES = 4096,
  parameter int unsigned CNT_W = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  in_item_t         item_i,
  input  logic [LenW-1:0]  sub_len_i,
  output logic             job_push_o,
  output job_t             job_o,
  output logic [CNT_W-1:0] job_cnt_o
);

  logic [PeakW-1:0]   peak_q;
  logic [EnergyW-1:0] energy_q;
  logic [PosW-1:0]    pos_q;
  logic [CNT_W-1:0]   cnt_q;

  logic [LenW-1:0]    len_eff;
  logic [PeakW-1:0]   peak_nx;
  logic [CNT_W-1:0]   cnt_nx;
  logic               run_done;
  logic [EnergyW:0]   sum;
  logic [EnergyW-1:0] energy_add;

  always_comb begin
    if (sub_len_i == '0) begin
      len_eff = LenW'(1);
    end else if (sub_len_i > LenW'(LenMax)) begin
      len_eff = LenW'(LenMax);
    end else begin
      len_eff = sub_len_i;
    end
  end

  // only samples with the sign bit clear take part in the peak
  assign peak_nx = (!item_i.sample[SampleW-1] && (item_i.sample[PeakW-1:0] > peak_q)) ?
                   item_i.sample[PeakW-1:0] : peak_q;
  assign cnt_nx  = (cnt_q < CNT_W'(MAX_BUFFER_SAMPLES)) ? cnt_q + 1'b1 : cnt_q;
  assign run_done = (({1'b0, pos_q} + LenW'(1)) >= len_eff);

  // a closing run and a buffer end never both add: a closed run leaves position 0
  assign sum        = {1'b0, energy_q} + (EnergyW + 1)'(peak_nx);
  assign energy_add = sum[EnergyW] ? '1 : sum[EnergyW-1:0];

  assign job_push_o = accept_i && item_i.last_in_buffer;
  assign job_o.energy = (run_done || item_i.last_in_buffer) ? energy_add : energy_q;
  assign job_o.len    = len_eff;
  assign job_cnt_o    = cnt_nx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q   <= '0;
      energy_q <= '0;
      pos_q    <= '0;
      cnt_q    <= '0;
    end else if (accept_i) begin
      if (item_i.last_in_buffer) begin
        peak_q   <= '0;
        energy_q <= '0;
        pos_q    <= '0;
        cnt_q    <= '0;
      end else begin
        cnt_q <= cnt_nx;
        if (run_done) begin
          peak_q   <= '0;
          energy_q <= energy_add;
          pos_q    <= '0;
        end else begin
          peak_q <= peak_nx;
          pos_q  <= pos_q + 1'b1;
        end
      end
    end
  end

endmodule

[sv/pled_back.sv]
`timescale 1ns / 1ps
// per-buffer mean peak divider, log volume and activity counter
module pled_back
  import pled_pkg::*;
#(
  parameter int unsigned CNT_W = 13,
  parameter int unsigned LOG_TABLE_DEPTH = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_empty_i,
  input  job_t             job_i,
  input  logic [CNT_W-1:0] job_cnt_i,
  output logic             job_pop_o,
  input  back_cfg_t        cfg_i,
  input  logic             res_full_i,
  output logic             res_push_o,
  output out_item_t        res_o
);

  localparam int unsigned IdxW     = $clog2(LOG_TABLE_DEPTH);
  localparam int unsigned DepthW   = $clog2(LOG_TABLE_DEPTH + 1);
  localparam int unsigned FracIdxW = $clog2(FracW);
  localparam int unsigned FracNW   = $clog2(FracW + 1);
  localparam int unsigned GW       = QIdxW + TableW;
  localparam int unsigned AgW      = AmpW + GW;
  localparam int unsigned VW       = AgW + Ln2W;
  localparam int unsigned ProdW    = EnergyW + LenW;

  localparam int unsigned StW = 4;
  localparam logic [StW-1:0] S_IDLE = 4'd0;
  localparam logic [StW-1:0] S_DIV  = 4'd1;
  localparam logic [StW-1:0] S_IDX  = 4'd2;
  localparam logic [StW-1:0] S_ROM  = 4'd3;
  localparam logic [StW-1:0] S_MUL1 = 4'd4;
  localparam logic [StW-1:0] S_MUL2 = 4'd5;
  localparam logic [StW-1:0] S_VOL  = 4'd6;
  localparam logic [StW-1:0] S_CNT  = 4'd7;
  localparam logic [StW-1:0] S_PUSH = 4'd8;

  // log2(1 + i/depth) in q16, built at elaboration
  logic [TableW-1:0] log_rom [LOG_TABLE_DEPTH];
  for (genvar gi = 0; gi < LOG_TABLE_DEPTH; gi++) begin : g_rom
    localparam logic [63:0] X0 = ((64'(LOG_TABLE_DEPTH) + 64'(gi)) << 30) / LOG_TABLE_DEPTH;
    assign log_rom[gi] = log2_frac(X0);
  end

  logic [StW-1:0]    state_q;
  logic [ActW-1:0]   act_q;

  logic [NumW-1:0]   num_q;
  logic [CNT_W-1:0]  den_q, rem_q;
  logic [QIdxW-1:0]  bit_q, e_q;
  logic              lead_q;
  logic [FracW-1:0]  frac_q;
  logic [FracNW-1:0] nfrac_q;
  logic [IdxW-1:0]   idx_q;
  logic              zero_q;
  logic [TableW-1:0] t_q;
  logic [AgW-1:0]    ag_q;
  logic [VW-1:0]     v_q;
  logic [VolW-1:0]   vol_q;

  logic [CNT_W:0]          rem_ext, rem_sub;
  logic                    q_bit;
  logic [CNT_W-1:0]        rem_nx;
  logic [ProdW-1:0]        prod;
  logic [FracW+DepthW-1:0] idx_prod;
  logic [GW-1:0]           log_q16;
  logic [VW-33:0]          vol_hi;
  logic [ActW:0]           act_up;
  logic                    clip;
  logic [ActW-1:0]         clip_val, act_dn;

  // restoring division, one quotient bit a cycle
  assign rem_ext = {rem_q, num_q[NumW-1]};
  assign q_bit   = (rem_ext >= {1'b0, den_q});
  assign rem_sub = rem_ext - {1'b0, den_q};
  assign rem_nx  = q_bit ? rem_sub[CNT_W-1:0] : rem_ext[CNT_W-1:0];

  assign prod     = ProdW'(job_i.energy) * ProdW'(job_i.len);
  assign idx_prod = (FracW + DepthW)'(frac_q) * (FracW + DepthW)'(LOG_TABLE_DEPTH);
  assign log_q16  = {e_q - QIdxW'(FracBits), t_q};
  assign vol_hi   = v_q[VW-1:32];

  assign act_up   = {1'b0, act_q} + (ActW + 1)'(cfg_i.rise_step);
  assign clip     = (act_up[ActW:CntShift] > (ActW + 1 - CntShift)'(cfg_i.counter_max));
  assign clip_val = ActW'({cfg_i.counter_max, {CntShift{1'b0}}});
  assign act_dn   = (act_q < ActW'(cfg_i.fall_step)) ? '0 : act_q - ActW'(cfg_i.fall_step);

  assign job_pop_o  = (state_q == S_IDLE) && !job_empty_i;
  assign res_push_o = (state_q == S_PUSH) && !res_full_i;
  assign res_o.activity_level = act_q[CntShift +: LevelW];
  assign res_o.volume         = vol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      act_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (!job_empty_i) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (bit_q == '0) begin
            state_q <= S_IDX;
          end
        end
        S_IDX:  state_q <= S_ROM;
        S_ROM:  state_q <= S_MUL1;
        S_MUL1: state_q <= S_MUL2;
        S_MUL2: state_q <= S_VOL;
        S_VOL:  state_q <= S_CNT;
        S_CNT: begin
          if (vol_q > cfg_i.threshold) begin
            act_q <= clip ? clip_val : act_up[ActW-1:0];
          end else begin
            act_q <= act_dn;
          end
          state_q <= S_PUSH;
        end
        S_PUSH: begin
          if (!res_full_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        num_q   <= {prod, FracBits'(0)};
        den_q   <= job_cnt_i;
        rem_q   <= '0;
        bit_q   <= QIdxW'(NumW - 1);
        lead_q  <= 1'b0;
        frac_q  <= '0;
        nfrac_q <= '0;
      end
      S_DIV: begin
        rem_q <= rem_nx;
        num_q <= num_q << 1;
        bit_q <= bit_q - 1'b1;
        // first set quotient bit marks the exponent, the next bits fill the fraction
        if (q_bit && !lead_q) begin
          lead_q <= 1'b1;
          e_q    <= bit_q;
        end else if (lead_q && (nfrac_q < FracNW'(FracW))) begin
          frac_q[FracIdxW'(FracW - 1) - nfrac_q[FracIdxW-1:0]] <= q_bit;
          nfrac_q <= nfrac_q + 1'b1;
        end
      end
      S_IDX: begin
        idx_q  <= idx_prod[FracW +: IdxW];
        zero_q <= !lead_q || (e_q < QIdxW'(FracBits));
      end
      S_ROM:  t_q  <= log_rom[idx_q];
      S_MUL1: ag_q <= AgW'(cfg_i.amplify) * AgW'(log_q16);
      S_MUL2: v_q  <= VW'(ag_q) * VW'(LN2_Q16);
      S_VOL: begin
        if (zero_q) begin
          vol_q <= '0;
        end else if (vol_hi > (VW - 32)'(VOLUME_MAX)) begin
          vol_q <= VolW'(VOLUME_MAX);
        end else begin
          vol_q <= vol_hi[VolW-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

[dv/peak_energy_level_detector_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench of the peak energy level detector with its own level tracker

import pled_pkg::*;

localparam int unsigned MaxSamples = 4096;
localparam int unsigned TableDepth = 256;

class level_tracker;
  logic [LenW-1:0]    sub_len;
  logic [AmpW-1:0]    amp;
  logic [VolW-1:0]    thr;
  logic [StepW-1:0]   rise;
  logic [StepW-1:0]   fall;
  logic [StepW-1:0]   cmax;

  logic [PeakW-1:0]   peak;
  logic [EnergyW-1:0] energy;
  logic [PosW-1:0]    pos;
  logic [12:0]        count;
  logic [ActW-1:0]    act;

  out_item_t   pending_levels[$];
  int unsigned mismatches;
  int unsigned seen;

  function new();
    sub_len = 11'd100;
    amp     = 8'd10;
    thr     = 12'd40;
    rise    = 16'd16;
    fall    = 16'd1;
    cmax    = 16'd100;
    peak    = '0;
    energy  = '0;
    pos     = '0;
    count   = '0;
    act     = '0;
    mismatches = 0;
    seen       = 0;
  endfunction

  function void report(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endfunction

  function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
    case (idx)
      REG_SUB_LEN:     sub_len = d[LenW-1:0];
      REG_AMPLIFY:     amp     = d[AmpW-1:0];
      REG_THRESHOLD:   thr     = d[VolW-1:0];
      REG_RISE_STEP:   rise    = d;
      REG_FALL_STEP:   fall    = d;
      REG_COUNTER_MAX: cmax    = d;
      default: ;
    endcase
  endfunction

  function int unsigned eff_len();
    if (sub_len == '0) return 1;
    if (32'(sub_len) > LenMax) return LenMax;
    return 32'(sub_len);
  endfunction

  function void add_energy();
    logic [EnergyW:0] s;
    s = {1'b0, energy} + (EnergyW + 1)'(peak);
    energy = s[EnergyW] ? '1 : s[EnergyW-1:0];
  endfunction

  // log2 of the mean peak via leading one and table index, scaled by amplify * ln2
  function logic [VolW-1:0] volume_of(logic [63:0] mean);
    int                msb;
    logic [63:0]       top;
    logic [63:0]       idx;
    logic [63:0]       x;
    logic [63:0]       g;
    logic [63:0]       v;
    logic [TableW-1:0] frac_log;
    if (mean == '0) return '0;
    msb = 63;
    while (!mean[msb]) msb--;
    if (msb < int'(FracBits)) return '0;
    top = mean << (63 - msb);
    idx = (((top >> 31) & 64'hFFFF_FFFF) * 64'(TableDepth)) >> 32;
    x = ((64'(TableDepth) + idx) << 30) / 64'(TableDepth);
    frac_log = '0;
    for (int k = TableW - 1; k >= 0; k--) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        frac_log[k] = 1'b1;
      end
    end
    g = 64'(msb - int'(FracBits)) * 64'd65536 + 64'(frac_log);
    v = (64'(amp) * g * 64'(LN2_Q16)) >> 32;
    if (v > 64'(VOLUME_MAX)) return VolW'(VOLUME_MAX);
    return VolW'(v);
  endfunction

  function void take_sample(in_item_t beat);
    int unsigned     run;
    logic [63:0]     mean;
    logic [VolW-1:0] vol;
    logic [31:0]     c;
    out_item_t       lvl;
    run = eff_len();
    if (!beat.sample[SampleW-1] && beat.sample[PeakW-1:0] > peak) peak = beat.sample[PeakW-1:0];
    if (32'(count) < MaxSamples) count = count + 1'b1;
    // a run closes also when the position already sits past a shortened run
    if (32'(pos) + 1 >= run) begin
      add_energy();
      peak = '0;
      pos  = '0;
    end else begin
      pos = pos + 1'b1;
    end
    if (!beat.last_in_buffer) return;

    if (pos != '0) add_energy();
    mean = (64'(energy) * 64'(run) * 64'(1 << FracBits)) / 64'(count);
    vol = volume_of(mean);
    if (vol > thr) begin
      c = 32'(act) + 32'(rise);
      if (c / COUNTER_SCALE > 32'(cmax)) c = 32'(cmax) * COUNTER_SCALE;
      act = c[ActW-1:0];
    end else if (act < ActW'(fall)) begin
      act = '0;
    end else begin
      act = act - ActW'(fall);
    end
    lvl.activity_level = LevelW'(act / ActW'(COUNTER_SCALE));
    lvl.volume         = vol;
    pending_levels.push_back(lvl);
    peak   = '0;
    energy = '0;
    pos    = '0;
    count  = '0;
  endfunction

  function void check_level(out_item_t got);
    out_item_t want;
    seen++;
    if (pending_levels.size() == 0) begin
      report($sformatf("level beat %0d arrived with none expected", seen));
      return;
    end
    want = pending_levels.pop_front();
    if (got.activity_level !== want.activity_level)
      report($sformatf("beat %0d activity_level got %0d want %0d", seen,
                       got.activity_level, want.activity_level));
    if (got.volume !== want.volume)
      report($sformatf("beat %0d volume got %0d want %0d", seen, got.volume, want.volume));
  endfunction
endclass

module peak_energy_level_detector_tb;
  import pled_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpareLo = CfgIdxW'(REG_COUNTER_MAX + 1);
  localparam logic [CfgIdxW-1:0] RegSpareHi = '1;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                push      = 1'b0;
  logic                full;
  in_item_t            in_item   = '0;
  logic                pop       = 1'b0;
  logic                empty;
  out_item_t           out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  level_tracker sb;
  int unsigned  in_idle_pct  = 0;
  int unsigned  out_idle_pct = 0;

  peak_energy_level_detector #(
    .MAX_BUFFER_SAMPLES(MaxSamples),
    .LOG_TABLE_DEPTH(TableDepth)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .pop        (pop),
    .empty      (empty),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned pick_idle();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 50;
    endcase
  endfunction

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk_i); while (!cfg_ready);
    sb.write_reg(idx, d);
  endtask

  task automatic apply_setting(input logic [CfgDataW-1:0] len, amp, thr, rise, fall, cmax);
    put_reg(REG_SUB_LEN, len);
    put_reg(REG_AMPLIFY, amp);
    put_reg(REG_THRESHOLD, thr);
    put_reg(REG_RISE_STEP, rise);
    put_reg(REG_FALL_STEP, fall);
    put_reg(REG_COUNTER_MAX, cmax);
    cfg_valid <= 1'b0;
  endtask

  // push stays high across back-to-back beats, dropped only for an idle burst
  task automatic send(input logic [SampleW-1:0] s, input logic last);
    in_item_t beat;
    beat.sample         = s;
    beat.last_in_buffer = last;
    if ($urandom_range(99) < in_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= beat;
    do @(posedge clk_i); while (full);
    sb.take_sample(beat);
  endtask

  // buffers of random length and character; the last one may stay open
  task automatic run_buffers(input int unsigned n);
    int unsigned      sent;
    int unsigned      blen;
    int unsigned      upper;
    int unsigned      pick;
    int unsigned      mode;
    logic [SampleW-1:0] s;
    sent = 0;
    while (sent < n) begin
      upper = sb.eff_len() * 3;
      if (upper > 60) upper = 60;
      pick = $urandom_range(0, 9);
      if (pick < 6) blen = $urandom_range(1, upper);
      else if (pick < 9) blen = $urandom_range(1, 4);
      else blen = $urandom_range(60, 400);
      mode = $urandom_range(0, 3);
      for (int i = 0; i < int'(blen) && sent < n; i++) begin
        case (mode)
          0: s = SampleW'($urandom);
          1: s = SampleW'($urandom_range(0, 31) - 16);
          // silence: zero or negative only
          2: s = $urandom_range(0, 1) ? '0 : {1'b1, 15'($urandom)};
          default: s = {1'b0, 15'($urandom_range(16384, 32767))};
        endcase
        send(s, i == int'(blen) - 1);
        sent++;
      end
    end
  endtask

  task automatic wait_idle();
    while (sb.pending_levels.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  initial begin
    int unsigned pop_hold;
    pop_hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) sb.check_level(out_item);
      if (pop_hold > 0) begin
        pop <= 1'b0;
        pop_hold--;
      end else if ($urandom_range(99) < out_idle_pct) begin
        pop <= 1'b0;
        pop_hold = $urandom_range(0, 7);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // indexes outside the register map are ignored
    put_reg(RegSpareLo, CfgDataW'($urandom));
    put_reg(RegSpareHi, CfgDataW'($urandom));
    cfg_valid <= 1'b0;

    in_idle_pct  = 20;
    out_idle_pct = 20;
    send(16'h7FFF, 1'b1);
    send(16'h8000, 1'b1);
    send(16'h0000, 1'b1);
    send(16'h0001, 1'b1);
    send(16'hFFFF, 1'b0);
    send(16'h5555, 1'b0);
    send(16'h2AAA, 1'b1);
    send(16'h7FFE, 1'b0);
    send(16'hAAAA, 1'b0);
    send(16'h4000, 1'b0);
    send(16'h3FFF, 1'b1);
    push <= 1'b0;
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: apply_setting(16'd0, 16'd255, 16'd0, 16'hFFFF, 16'd0, 16'd3);
        1: apply_setting(16'd2047, 16'd255, 16'd4095, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: apply_setting(16'd1024, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        3: apply_setting(16'd1, 16'd255, 16'd0, 16'hFFFF, 16'd1, 16'hFFFF);
        default: apply_setting(CfgDataW'($urandom_range(1, 40)), CfgDataW'($urandom_range(0, 255)),
                               CfgDataW'($urandom_range(0, 400)),
                               CfgDataW'($urandom_range(0, 2000)),
                               CfgDataW'($urandom_range(0, 2000)),
                               CfgDataW'($urandom_range(0, 300)));
      endcase
      in_idle_pct  = pick_idle();
      out_idle_pct = pick_idle();
      if (ph == 0) begin
        // mean peak rounds down to zero
        send(16'h0001, 1'b0);
        repeat (255) send(16'h0000, 1'b0);
        send(16'h0000, 1'b1);
        // mean peak below one, so the log is negative
        send(16'h0001, 1'b0);
        send(16'h0000, 1'b0);
        send(16'h0000, 1'b1);
      end
      run_buffers(30);
      push <= 1'b0;
      wait_idle();
    end

    // closing stretch without idling
    in_idle_pct  = 0;
    out_idle_pct = 0;
    apply_setting(16'd1, 16'd17, 16'd100, 16'd300, 16'd200, 16'd500);
    run_buffers(20);
    push <= 1'b0;
    wait_idle();

    if (sb.pending_levels.size() != 0)
      sb.report($sformatf("%0d expected levels never arrived", sb.pending_levels.size()));
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
sv/pled_pkg.sv
sv/pled_fifo.sv
sv/pled_front.sv
sv/pled_back.sv
sv/peak_energy_level_detector.sv
dv/peak_energy_level_detector_tb.sv
